// ----- hw/rtl/ait_pkg.sv -----
// ----------------------------------------------------------------------------
// ait_pkg
// Shared constants for the inverse acoustic tensor block: default widths,
// stream and configuration port widths, and the flag positions in tuser.
// ----------------------------------------------------------------------------
`default_nettype none

package ait_pkg;

  // Default datapath widths.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int WAVE_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF  = 16;

  // Result stream: four Q16.16 entries in tdata, two flags in tuser.
  localparam int GREEN_W     = 32;
  localparam int NUM_GREEN   = 4;
  localparam int OUT_TDATA_W = GREEN_W * NUM_GREEN;
  localparam int OUT_TUSER_W = 8;

  localparam int TUSER_SINGULAR  = 0;
  localparam int TUSER_SATURATED = 1;

  // Configuration port: six 64-bit coefficient registers.
  localparam int NUM_COEF_REGS = 6;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int COEF_HI_LSB   = 32;

endpackage : ait_pkg

`default_nettype wire

// ----- hw/rtl/inverse_acoustic_tensor_2d.sv -----
// Throughput: one wave vector per cycle while the skid stage is empty; the
// divider retires one quotient bit per pipeline stage, so its depth sets the
// latency and not the rate.
// Reset: rst_n is synchronous and active low; it clears all valid bits,
// including those of the output and skid registers, and the coefficient registers.
// ----------------------------------------------------------------------------
// inverse_acoustic_tensor_2d
// Forms the 2x2 acoustic tensor from a wave vector and the stored stiffness
// coefficients and returns its inverse in fixed point, with singular and
// saturation flags.
// ----------------------------------------------------------------------------
`default_nettype none

module inverse_acoustic_tensor_2d #(
  parameter int DATA_WIDTH = ait_pkg::DATA_WIDTH_DEF,
  parameter int WAVE_WIDTH = ait_pkg::WAVE_WIDTH_DEF,
  parameter int FRAC_BITS  = ait_pkg::FRAC_BITS_DEF,
  localparam int IN_TDATA_W = ((2 * WAVE_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [WAVE_WIDTH-1:0] wave_x, [2*WAVE_WIDTH-1:WAVE_WIDTH] wave_y, rest zero
  input  logic [IN_TDATA_W-1:0]             in_tdata,
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] green_11, [63:32] green_12, [95:64] green_21, [127:96] green_22
  output logic [ait_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] singular, [1] saturated, rest zero
  output logic [ait_pkg::OUT_TUSER_W-1:0]   out_tuser,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ait_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ait_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import ait_pkg::*;

  localparam int D      = DATA_WIDTH;
  localparam int PQ_W   = 2 * WAVE_WIDTH;
  localparam int PM_W   = 2 * D;
  localparam int DEN_W  = 2 * D + 1;
  localparam int REM_W  = 2 * D + 2;
  localparam int CL_W   = (PQ_W > REM_W) ? PQ_W : REM_W;
  localparam int NSTEP  = D + 2 * FRAC_BITS;
  localparam int DIV0   = 7;
  localparam int NVLD   = DIV0 + NSTEP;
  localparam int NCOEF  = 2 * NUM_COEF_REGS;

  localparam logic signed [CL_W-1:0] CL_HI = {{(CL_W - D + 1){1'b0}}, {(D - 1){1'b1}}};
  localparam logic signed [CL_W-1:0] CL_LO = ~CL_HI;
  localparam logic [D-1:0] VAL_HI  = {1'b0, {(D - 1){1'b1}}};
  localparam logic [D-1:0] VAL_LO  = {1'b1, {(D - 1){1'b0}}};
  localparam logic [D:0]   QUO_POS = {2'b00, {(D - 1){1'b1}}};
  localparam logic [D:0]   QUO_NEG = {2'b01, {(D - 1){1'b0}}};

  typedef struct packed {
    logic         sat;
    logic [D-1:0] val;
  } clip_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [D-1:0]     nsh;
    logic [D:0]       quo;
    logic             big;
    logic             neg;
    logic [D-1:0]     alt;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_GREEN-1:0] lane;
    logic [DEN_W-1:0]      den;
    logic                  zero;
    logic                  sat;
  } div_t;

  typedef struct packed {
    logic [NUM_GREEN-1:0][D-1:0] green;
    logic                        singular;
    logic                        saturated;
  } res_t;

  // Clip a wide signed value to the DATA_WIDTH range.
  function automatic clip_t clip_d(input logic signed [CL_W-1:0] v);
    clip_t r;
    r.sat = 1'b1;
    if (v > CL_HI) begin
      r.val = VAL_HI;
    end else if (v < CL_LO) begin
      r.val = VAL_LO;
    end else begin
      r.sat = 1'b0;
      r.val = v[D-1:0];
    end
    return r;
  endfunction

  // One restoring division step on all four lanes.
  function automatic div_t div_step(input div_t x);
    div_t             y;
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] dd;
    y  = x;
    dd = REM_W'(x.den);
    for (int l = 0; l < NUM_GREEN; l++) begin
      r2 = {x.lane[l].rem[REM_W-2:0], x.lane[l].nsh[D-1]};
      y.lane[l].nsh = {x.lane[l].nsh[D-2:0], 1'b0};
      y.lane[l].big = x.lane[l].big | x.lane[l].quo[D];
      if (r2 >= dd) begin
        y.lane[l].rem = r2 - dd;
        y.lane[l].quo = {x.lane[l].quo[D-1:0], 1'b1};
      end else begin
        y.lane[l].rem = r2;
        y.lane[l].quo = {x.lane[l].quo[D-1:0], 1'b0};
      end
    end
    return y;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] coef_reg_r [NUM_COEF_REGS];
  logic signed [D-1:0]   coef_w     [NCOEF];

  assign cfg_ready = 1'b1;

  // A write beyond the register list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF_REGS; i++) begin
        coef_reg_r[i] <= '0;
      end
    end else if (cfg_valid && (32'(cfg_addr) < NUM_COEF_REGS)) begin
      coef_reg_r[cfg_addr] <= cfg_data;
    end
  end

  // Each register holds two coefficients, the first in the low half.
  for (genvar k = 0; k < NCOEF; k++) begin : g_coef
    if (k % 2 == 1) begin : g_hi
      assign coef_w[k] = coef_reg_r[k / 2][COEF_HI_LSB + D - 1:COEF_HI_LSB];
    end else begin : g_lo
      assign coef_w[k] = coef_reg_r[k / 2][D - 1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: the whole pipeline moves unless the skid stage is full
  // --------------------------------------------------------------------------
  logic            en;
  logic [NVLD:1]   vld_r;
  logic            out_v_r;
  logic            skid_v_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NVLD-1:1], in_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: squares and cross product of the wave vector
  // --------------------------------------------------------------------------
  logic signed [WAVE_WIDTH-1:0] kx, ky;
  logic signed [PQ_W-1:0]       s1_pxx_r, s1_pxy_r, s1_pyy_r;

  assign kx = in_tdata[WAVE_WIDTH-1:0];
  assign ky = in_tdata[2*WAVE_WIDTH-1:WAVE_WIDTH];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pxx_r <= kx * kx;
      s1_pxy_r <= kx * ky;
      s1_pyy_r <= ky * ky;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale and clip the quadratic terms
  // --------------------------------------------------------------------------
  logic signed [D-1:0]    s2_q_r [3];
  logic                   s2_sat_r;
  logic signed [PQ_W-1:0] s2_sh [3];
  clip_t                  s2_cl [3];

  always_comb begin
    s2_sh[0] = s1_pxx_r >>> FRAC_BITS;
    s2_sh[1] = s1_pxy_r >>> FRAC_BITS;
    s2_sh[2] = s1_pyy_r >>> FRAC_BITS;
    for (int j = 0; j < 3; j++) begin
      s2_cl[j] = clip_d(CL_W'(s2_sh[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s2_q_r[j] <= s2_cl[j].val;
      end
      s2_sat_r <= s2_cl[0].sat | s2_cl[1].sat | s2_cl[2].sat;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: coefficient products, three for each tensor entry
  // --------------------------------------------------------------------------
  logic signed [PM_W-1:0] s3_m_r [NCOEF];
  logic                   s3_sat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NCOEF; k++) begin
        s3_m_r[k] <= coef_w[k] * s2_q_r[k % 3];
      end
      s3_sat_r <= s2_sat_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: sum the scaled products into the tensor entries
  // --------------------------------------------------------------------------
  logic signed [D-1:0]    s4_t_r [NUM_GREEN];
  logic                   s4_sat_r;
  logic signed [CL_W-1:0] s4_sum [NUM_GREEN];
  logic signed [PM_W-1:0] s4_sh  [NCOEF];
  clip_t                  s4_cl  [NUM_GREEN];
  logic                   s4_any;

  always_comb begin
    s4_any = 1'b0;
    for (int k = 0; k < NCOEF; k++) begin
      s4_sh[k] = s3_m_r[k] >>> FRAC_BITS;
    end
    for (int e = 0; e < NUM_GREEN; e++) begin
      s4_sum[e] = CL_W'(s4_sh[3*e]) + CL_W'(s4_sh[3*e+1]) + CL_W'(s4_sh[3*e+2]);
      s4_cl[e]  = clip_d(s4_sum[e]);
      s4_any    = s4_any | s4_cl[e].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < NUM_GREEN; e++) begin
        s4_t_r[e] <= s4_cl[e].val;
      end
      s4_sat_r <= s3_sat_r | s4_any;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: determinant products
  // --------------------------------------------------------------------------
  logic signed [PM_W-1:0] s5_pa_r, s5_pb_r;
  logic signed [D-1:0]    s5_t_r [NUM_GREEN];
  logic                   s5_sat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_pa_r  <= s4_t_r[0] * s4_t_r[3];
      s5_pb_r  <= s4_t_r[1] * s4_t_r[2];
      s5_t_r   <= s4_t_r;
      s5_sat_r <= s4_sat_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: determinant, exact at twice the fraction bits
  // --------------------------------------------------------------------------
  logic signed [DEN_W-1:0] s6_det_r;
  logic signed [D-1:0]     s6_t_r [NUM_GREEN];
  logic                    s6_sat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_det_r <= DEN_W'(s5_pa_r) - DEN_W'(s5_pb_r);
      s6_t_r   <= s5_t_r;
      s6_sat_r <= s5_sat_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: divider set-up (magnitudes, signs and the adjugate fallback)
  // --------------------------------------------------------------------------
  div_t                div_r [NSTEP+1];
  div_t                s7_nxt;
  logic signed [D:0]   s7_num [NUM_GREEN];
  logic signed [D:0]   s7_mag [NUM_GREEN];
  logic                s7_zero;
  clip_t               s7_n1, s7_n2;

  always_comb begin
    s7_num[0] = (D + 1)'(s6_t_r[3]);
    s7_num[1] = -((D + 1)'(s6_t_r[1]));
    s7_num[2] = -((D + 1)'(s6_t_r[2]));
    s7_num[3] = (D + 1)'(s6_t_r[0]);
    s7_n1     = clip_d(CL_W'(s7_num[1]));
    s7_n2     = clip_d(CL_W'(s7_num[2]));
    s7_zero   = (s6_det_r == '0);
    s7_nxt.den  = s6_det_r[DEN_W-1] ? DEN_W'(-s6_det_r) : DEN_W'(s6_det_r);
    s7_nxt.zero = s7_zero;
    s7_nxt.sat  = s6_sat_r | (s7_zero & (s7_n1.sat | s7_n2.sat));
    for (int l = 0; l < NUM_GREEN; l++) begin
      s7_mag[l]             = s7_num[l][D] ? -s7_num[l] : s7_num[l];
      s7_nxt.lane[l].rem    = '0;
      s7_nxt.lane[l].nsh    = s7_mag[l][D-1:0];
      s7_nxt.lane[l].quo    = '0;
      s7_nxt.lane[l].big    = 1'b0;
      s7_nxt.lane[l].neg    = s7_num[l][D] ^ s6_det_r[DEN_W-1];
    end
    s7_nxt.lane[0].alt = s6_t_r[3];
    s7_nxt.lane[1].alt = s7_n1.val;
    s7_nxt.lane[2].alt = s7_n2.val;
    s7_nxt.lane[3].alt = s6_t_r[0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0] <= s7_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: one quotient bit per stage
  // --------------------------------------------------------------------------
  for (genvar s = 0; s < NSTEP; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        div_r[s+1] <= div_step(div_r[s]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Final clamping to range and choice of the singular fallback
  // --------------------------------------------------------------------------
  res_t pipe_res;
  div_t fin;
  logic pipe_v;
  logic fin_sat;

  assign fin    = div_r[NSTEP];
  assign pipe_v = vld_r[NVLD];

  always_comb begin
    fin_sat = 1'b0;
    for (int l = 0; l < NUM_GREEN; l++) begin
      if (fin.zero) begin
        pipe_res.green[l] = fin.lane[l].alt;
      end else if (fin.lane[l].neg) begin
        if (fin.lane[l].big || (fin.lane[l].quo > QUO_NEG)) begin
          pipe_res.green[l] = VAL_LO;
          fin_sat           = 1'b1;
        end else begin
          pipe_res.green[l] = -fin.lane[l].quo[D-1:0];
        end
      end else begin
        if (fin.lane[l].big || (fin.lane[l].quo > QUO_POS)) begin
          pipe_res.green[l] = VAL_HI;
          fin_sat           = 1'b1;
        end else begin
          pipe_res.green[l] = fin.lane[l].quo[D-1:0];
        end
      end
    end
    pipe_res.singular  = fin.zero;
    pipe_res.saturated = fin.sat | fin_sat;
  end

  // --------------------------------------------------------------------------
  // Output register with a skid stage behind it
  // --------------------------------------------------------------------------
  res_t out_res_r, skid_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= pipe_v;
      end
    end else if (pipe_v && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_res_r <= skid_v_r ? skid_res_r : pipe_res;
    end else if (pipe_v && en) begin
      skid_res_r <= pipe_res;
    end
  end

  // Entries leave sign-extended to the stream field width.
  assign out_tvalid = out_v_r;

  for (genvar l = 0; l < NUM_GREEN; l++) begin : g_out
    assign out_tdata[GREEN_W*l +: GREEN_W] = GREEN_W'(signed'(out_res_r.green[l]));
  end

  always_comb begin
    out_tuser                  = '0;
    out_tuser[TUSER_SINGULAR]  = out_res_r.singular;
    out_tuser[TUSER_SATURATED] = out_res_r.saturated;
  end

endmodule : inverse_acoustic_tensor_2d

`default_nettype wire

// ----- hw/rtl/ait_checker.sv -----
// ----------------------------------------------------------------------------
// ait_checker
// Port-level checks on the inverse acoustic tensor block, bound to its top
// level.
// ----------------------------------------------------------------------------
`default_nettype none

module ait_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tready,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [ait_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic [ait_pkg::OUT_TUSER_W-1:0]   out_tuser,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready
);

  import ait_pkg::*;

  // A stalled result holds its valid and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // The input side only closes after the result side stalled a transfer.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without a result stall");

  // Coefficient writes are never back-pressured.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule : ait_checker

bind inverse_acoustic_tensor_2d ait_checker u_ait_checker (.*);

`default_nettype wire
